// ----- rtl/sts_pkg.sv -----
package sts_pkg;

    localparam int MAX_ORDER = 31;

    localparam int ANGLE_W = 20;
    localparam int POW_W   = 6;
    localparam int SUM_W   = 28;
    localparam int MAG_W   = 27;
    localparam int X2_W    = 23;
    localparam int RCP_W   = 30;
    localparam int IDX_W   = 5;
    localparam int PRD_W   = MAG_W + RCP_W;
    localparam int P_W     = 34;
    localparam int PL_W    = 17;
    localparam int LO_W    = PL_W + RCP_W;

    // largest odd order not above MAX_ORDER
    localparam logic [POW_W-1:0] EFF_MAX = POW_W'((MAX_ORDER - 1) | 1);

    localparam logic [MAG_W-1:0] TERM_MAG_MAX = {MAG_W{1'b1}};

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_P,
        MUL_LO,
        MUL_HI
    } t_mul_sel;

    typedef struct packed {
        logic             load;
        logic             bad;
        logic             mul_en;
        t_mul_sel         mul_sel;
        logic             x2_ld;
        logic             p_ld;
        logic             acc;
        logic             sum_add;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    // round(2^32 / ((2k) * (2k+1))), k = term index
    function automatic logic [RCP_W-1:0] recip(input logic [IDX_W-1:0] idx);
        logic [RCP_W-1:0] r;
        case (idx)
            5'd1:    r = 30'd715827883;
            5'd2:    r = 30'd214748365;
            5'd3:    r = 30'd102261126;
            5'd4:    r = 30'd59652324;
            5'd5:    r = 30'd39045157;
            5'd6:    r = 30'd27531842;
            5'd7:    r = 30'd20452225;
            5'd8:    r = 30'd15790321;
            5'd9:    r = 30'd12558384;
            5'd10:   r = 30'd10226113;
            5'd11:   r = 30'd8488078;
            5'd12:   r = 30'd7158279;
            5'd13:   r = 30'd6118187;
            5'd14:   r = 30'd5289369;
            5'd15:   r = 30'd4618244;
            5'd16:   r = 30'd4067204;
            5'd17:   r = 30'd3609216;
            5'd18:   r = 30'd3224450;
            5'd19:   r = 30'd2898089;
            5'd20:   r = 30'd2618882;
            5'd21:   r = 30'd2378166;
            5'd22:   r = 30'd2169175;
            5'd23:   r = 30'd1986571;
            5'd24:   r = 30'd1826092;
            5'd25:   r = 30'd1684301;
            5'd26:   r = 30'd1558406;
            5'd27:   r = 30'd1446117;
            5'd28:   r = 30'd1345541;
            5'd29:   r = 30'd1255104;
            5'd30:   r = 30'd1173488;
            5'd31:   r = 30'd1099582;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/sts_dp.sv -----
module sts_dp
    import sts_pkg::*;
(
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic [ANGLE_W-1:0] i_angle,
    output logic [SUM_W-1:0]   o_sine_value,
    output logic               o_saturated,
    output logic               o_bad_order
);

    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    logic [X2_W-1:0]  r_x2;
    logic [PRD_W-1:0] r_prod;
    logic [LO_W-1:0]  r_lo;
    logic [P_W-1:0]   r_p;
    logic [SUM_W-1:0] r_sum;
    logic             r_sat;
    logic             r_bad;

    logic             ang_neg;
    logic [ANGLE_W-1:0] ang_mag;
    logic [MAG_W-1:0] mul_a;
    logic [RCP_W-1:0] mul_b;
    logic [RCP_W-1:0] rcp;
    logic [40:0]      sq_rnd;
    logic [50:0]      pr_rnd;
    logic [64:0]      acc_w;
    logic             term_clip;
    logic [MAG_W-1:0] term_mag;
    logic [SUM_W:0]   term_s;
    logic [SUM_W:0]   sum_w;
    logic             sum_hi;
    logic             sum_lo;

    always_comb begin
        ang_neg = i_angle[ANGLE_W-1];
        ang_mag = ang_neg ? (~i_angle + ANGLE_W'(1)) : i_angle;
        rcp     = recip(i_cmd.idx);

        case (i_cmd.mul_sel)
            MUL_SQ: begin
                mul_a = r_mag;
                mul_b = RCP_W'(r_mag);
            end
            MUL_P: begin
                mul_a = r_mag;
                mul_b = RCP_W'(r_x2);
            end
            MUL_LO: begin
                mul_a = MAG_W'(r_p[PL_W-1:0]);
                mul_b = rcp;
            end
            MUL_HI: begin
                mul_a = MAG_W'(r_p[P_W-1:PL_W]);
                mul_b = rcp;
            end
            default: begin
                mul_a = r_mag;
                mul_b = '0;
            end
        endcase

        // x^2 back to Q.16, half up
        sq_rnd = {1'b0, r_prod[39:0]} + 41'h8000;
        // term * x^2 back to Q.16, half up
        pr_rnd = {1'b0, r_prod[49:0]} + 51'h8000;

        // p * recip = (hi << 17) + lo, rounded out of Q.32
        acc_w     = {1'b0, r_prod[LO_W-1:0], 17'b0} + 65'(r_lo) + 65'h8000_0000;
        term_clip = |acc_w[64:59];
        term_mag  = term_clip ? TERM_MAG_MAX : acc_w[58:32];

        term_s = r_neg ? (~{2'b0, r_mag} + (SUM_W+1)'(1)) : {2'b0, r_mag};
        sum_w  = {r_sum[SUM_W-1], r_sum} + term_s;
        sum_hi = !sum_w[SUM_W] && sum_w[SUM_W-1];
        sum_lo = sum_w[SUM_W] && !sum_w[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= MAG_W'(ang_mag);
            r_neg <= ang_neg;
            r_sum <= i_cmd.bad ? '0 : {{(SUM_W-ANGLE_W){i_angle[ANGLE_W-1]}}, i_angle};
            r_sat <= 1'b0;
            r_bad <= i_cmd.bad;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PRD_W'(mul_a) * PRD_W'(mul_b);
        end
        if (i_cmd.mul_en && i_cmd.mul_sel == MUL_HI) begin
            r_lo <= r_prod[LO_W-1:0];
        end
        if (i_cmd.x2_ld) begin
            r_x2 <= sq_rnd[16 +: X2_W];
        end
        if (i_cmd.p_ld) begin
            r_p <= pr_rnd[16 +: P_W];
        end
        if (i_cmd.acc) begin
            r_mag <= term_mag;
            r_neg <= ~r_neg;
            if (term_clip) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.sum_add) begin
            if (sum_hi) begin
                r_sum <= {1'b0, {(SUM_W-1){1'b1}}};
                r_sat <= 1'b1;
            end else if (sum_lo) begin
                r_sum <= {1'b1, {(SUM_W-1){1'b0}}};
                r_sat <= 1'b1;
            end else begin
                r_sum <= sum_w[SUM_W-1:0];
            end
        end
    end

    assign o_sine_value = r_sum;
    assign o_saturated  = r_sat;
    assign o_bad_order  = r_bad;

endmodule

// ----- rtl/sts_ctrl.sv -----
module sts_ctrl
    import sts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [POW_W-1:0] i_highest_power,
    output logic             busy,
    output logic             o_done,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_X2,
        S_MUL_P,
        S_RND,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_idx_max, n_idx_max;

    logic             accept;
    logic             bad;
    logic [POW_W-1:0] n_eff;
    logic [IDX_W-1:0] top_idx;

    always_comb begin
        accept  = start && !r_busy;
        bad     = !i_highest_power[0];
        n_eff   = (i_highest_power > EFF_MAX) ? EFF_MAX : i_highest_power;
        top_idx = n_eff[POW_W-1:1];

        n_state   = r_state;
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_idx     = r_idx;
        n_idx_max = r_idx_max;

        o_cmd         = '0;
        o_cmd.idx     = r_idx;
        o_cmd.bad     = bad;
        o_cmd.mul_sel = MUL_SQ;

        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    if (bad || top_idx == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_state   = S_SQ;
                        n_busy    = 1'b1;
                        n_idx     = IDX_W'(1);
                        n_idx_max = top_idx;
                    end
                end
            end
            S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
                n_state       = S_X2;
            end
            S_X2: begin
                o_cmd.x2_ld = 1'b1;
                n_state     = S_MUL_P;
            end
            S_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                // previous term joins the sum while this one starts
                o_cmd.sum_add = (r_idx != IDX_W'(1));
                n_state       = S_RND;
            end
            S_RND: begin
                o_cmd.p_ld = 1'b1;
                n_state    = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state       = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_idx == r_idx_max) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_MUL_P;
                end
            end
            S_FIN: begin
                o_cmd.sum_add = 1'b1;
                n_state       = S_IDLE;
                n_busy        = 1'b0;
                n_done        = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= IDX_W'(1);
            r_idx_max <= IDX_W'(1);
        end else begin
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_done    <= n_done;
            r_idx     <= n_idx;
            r_idx_max <= n_idx_max;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done strobe while busy");

    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_done && !r_busy))
        else $error("final step not followed by done");

    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !r_busy && !i_highest_power[0]) |=> (r_done && !r_busy))
        else $error("bad order not answered next cycle");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != '0 && r_idx <= r_idx_max))
        else $error("term index out of range");

    a_idle_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_busy)
        else $error("busy while idle");

endmodule

// ----- rtl/sine_taylor_series_top.sv -----
// Sine by truncated Maclaurin series: x - x^3/3! + x^5/5! ... up to x^n/n!.
// A word is accepted when start is high and busy is low; the result word
// shows on the o_ ports for exactly one cycle with o_done high and cannot be
// stalled, so the receiver must take it then. i_angle is signed Q4.16 in
// radians, i_highest_power the odd order n (orders above 31 are cut to 31).
// o_sine_value is signed Q12.16, clipped at its range, with o_saturated set
// if a term or the running sum was clipped. An even or zero order returns
// zero with o_bad_order set; that word, and order 1, arrive in the cycle after
// the accept. Otherwise busy stays high while the k = (n-1)/2 series terms
// after x are computed, and o_done strobes with busy low once the last
// term has joined the sum. All the arithmetic runs through one shared
// 27x30 multiplier: x^2 once, then per term the x^2 product, a rounding
// step, the reciprocal product in two halves and the clip. A new word may be
// started in the same cycle that the previous result is strobed out.
module sine_taylor_series_top
    import sts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ANGLE_W-1:0] i_angle,
    input  logic [POW_W-1:0]   i_highest_power,
    output logic               o_done,
    output logic [SUM_W-1:0]   o_sine_value,
    output logic               o_saturated,
    output logic               o_bad_order
);

    // controller to datapath commands, one set per cycle
    t_dp_cmd dp_cmd;

    sts_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_highest_power (i_highest_power),
        .busy            (busy),
        .o_done          (o_done),
        .o_cmd           (dp_cmd)
    );

    // datapath registers hold the result steady through the done cycle
    sts_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (dp_cmd),
        .i_angle      (i_angle),
        .o_sine_value (o_sine_value),
        .o_saturated  (o_saturated),
        .o_bad_order  (o_bad_order)
    );

endmodule

// ----- bench/sine_taylor_series_top_tb.sv -----
`timescale 1ns / 1ps

module sine_taylor_series_top_tb
    import sts_pkg::*;
();

    // Odd order cap; above this the series is cut short without a flag.
    localparam int  ORDER_CAP      = (MAX_ORDER - 1) | 1;
    localparam longint SUM_HI      = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO      = -(longint'(1) <<< (SUM_W - 1));
    localparam logic [63:0] TERM_LIMIT = 64'((longint'(1) <<< MAG_W) - 1);
    // Longest legal quiet stretch is well under WATCHDOG_LIMIT.
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  DRAIN_CYCLES   = 100;
    localparam int  PI_Q16         = 205887;

    typedef struct packed {
        logic [SUM_W-1:0] sine;
        logic             sat;
        logic             bad;
    } t_sine_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [ANGLE_W-1:0] i_angle;
    logic [POW_W-1:0]   i_highest_power;
    logic               o_done;
    logic [SUM_W-1:0]   o_sine_value;
    logic               o_saturated;
    logic               o_bad_order;

    t_sine_word sine_expect_q[$];
    t_sine_word got_word;
    t_sine_word want_word;
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;

    sine_taylor_series_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_angle         (i_angle),
        .i_highest_power (i_highest_power),
        .o_done          (o_done),
        .o_sine_value    (o_sine_value),
        .o_saturated     (o_saturated),
        .o_bad_order     (o_bad_order)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected result word for one angle / order pair.
    // Term magnitude is carried unsigned with a separate sign, and all
    // roundings are half up on the magnitude.
    function automatic t_sine_word predict_sine(input logic [ANGLE_W-1:0] angle,
                                                input logic [POW_W-1:0]   pow);
        t_sine_word  w;
        longint      x;
        longint      run_sum;
        logic [63:0] mag;
        logic [63:0] x_sq;
        logic [63:0] prod;
        logic [63:0] rcp;
        int          order;
        int          k;
        bit          neg;
        bit          clip;

        w    = '0;
        clip = 1'b0;
        if (pow == '0 || !pow[0]) begin
            w.bad = 1'b1;
            return w;
        end
        order = int'(pow);
        if (order > ORDER_CAP)
            order = ORDER_CAP;

        x       = $signed(angle);
        neg     = (x < 0);
        mag     = neg ? 64'(-x) : 64'(x);
        x_sq    = (mag * mag + 64'h8000) >> 16;
        run_sum = neg ? -longint'(mag) : longint'(mag);

        for (k = 3; k <= order; k += 2) begin
            // round(2^32 / ((k-1)*k)) from the 2^33 quotient
            rcp  = (((64'd1 << 33) / 64'((k - 1) * k)) + 64'd1) >> 1;
            prod = (mag * x_sq + 64'h8000) >> 16;
            mag  = (prod * rcp + 64'h8000_0000) >> 32;
            if (mag > TERM_LIMIT) begin
                mag  = TERM_LIMIT;
                clip = 1'b1;
            end
            neg      = !neg;
            run_sum += neg ? -longint'(mag) : longint'(mag);
            if (run_sum > SUM_HI) begin
                run_sum = SUM_HI;
                clip    = 1'b1;
            end else if (run_sum < SUM_LO) begin
                run_sum = SUM_LO;
                clip    = 1'b1;
            end
        end
        w.sine = run_sum[SUM_W-1:0];
        w.sat  = clip;
        return w;
    endfunction

    // Present one word from the falling edge and hold start until the edge
    // that accepts it. Start stays high on exit so the next word can follow
    // back to back; idle_gap lowers it.
    task automatic send_word(input logic [ANGLE_W-1:0] angle,
                             input logic [POW_W-1:0]   pow);
        @(negedge i_clk);
        start           = 1'b1;
        i_angle         = angle;
        i_highest_power = pow;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        sine_expect_q.push_back(predict_sine(angle, pow));
    endtask

    // Sender idle with start low and junk on the data ports; n sets the length of the gap.
    task automatic idle_gap(input int n);
        @(negedge i_clk);
        start           = 1'b0;
        i_angle         = ANGLE_W'($urandom);
        i_highest_power = POW_W'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Hold off until every outstanding result word is back.
    task automatic drain_results();
        idle_gap(1);
        while (sine_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly full-range angles, some around +/-pi, some at the extremes.
    // Orders are mostly odd; about one in sixteen is even or zero.
    task automatic send_random_word();
        logic [ANGLE_W-1:0] angle;
        logic [POW_W-1:0]   pow;
        int                 pick;
        int                 a;

        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            angle = ANGLE_W'($urandom);
        end else if (pick < 85) begin
            a     = int'($urandom_range(0, 2 * PI_Q16)) - PI_Q16;
            angle = a[ANGLE_W-1:0];
        end else begin
            a     = int'($urandom_range(0, 63));
            angle = ($urandom_range(0, 1) != 0) ? ANGLE_W'(20'h80000 + a)
                                                : ANGLE_W'(20'h7FFFF - a);
        end
        pow = POW_W'($urandom);
        if ($urandom_range(0, 7) != 0)
            pow[0] = 1'b1;
        send_word(angle, pow);
    endtask

    // Largest magnitudes each way, zero, one LSB, and the trivial order.
    task automatic test_angle_extremes();
        send_word(20'h7FFFF, 6'd31);
        send_word(20'h80000, 6'd31);
        send_word(20'h00000, 6'd31);
        send_word(20'h00001, 6'd1);
        send_word(20'hFFFFF, 6'd1);
        send_word(20'h7FFFF, 6'd1);
        send_word(20'h80000, 6'd3);
        // biggest terms near orders 7..9 at |x| = 8
        send_word(20'h7FFFF, 6'd7);
        send_word(20'h80000, 6'd9);
    endtask

    // Even and zero orders come back as zero with bad_order.
    task automatic test_bad_orders();
        send_word(20'h12345, 6'd0);
        send_word(20'h7FFFF, 6'd2);
        send_word(20'h80000, 6'd62);
        send_word(20'hFFFFF, 6'd0);
    endtask

    // Odd orders past the cap must match order 31.
    task automatic test_order_cap();
        send_word(ANGLE_W'(PI_Q16), 6'd31);
        send_word(ANGLE_W'(PI_Q16), 6'd33);
        send_word(ANGLE_W'(PI_Q16), 6'd63);
        send_word(ANGLE_W'(-PI_Q16), 6'd61);
    endtask

    // Low orders at one radian, both signs.
    task automatic test_low_orders();
        send_word(20'h10000, 6'd3);
        send_word(20'hF0000, 6'd5);
        send_word(20'h10000, 6'd7);
        send_word(20'hF0000, 6'd9);
    endtask

    // Random words with random sender gaps; every 200 words the sender
    // waits for the pipeline to empty.
    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 3)
                idle_gap($urandom_range(1, 8));
            send_random_word();
            if (i % 200 == 199)
                drain_results();
        end
    endtask

    // Closing stretch: no sender gaps at all.
    task automatic test_back_to_back(input int n);
        for (int i = 0; i < n; i++)
            send_random_word();
    endtask

    // Result checker: one expected word per o_done strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            got_word = '{o_sine_value, o_saturated, o_bad_order};
            if (sine_expect_q.size() == 0) begin
                $display("%0t: unexpected result word sine=%h sat=%b bad=%b",
                         $time, o_sine_value, o_saturated, o_bad_order);
                mismatch_count++;
            end else begin
                want_word = sine_expect_q.pop_front();
                if (got_word.sine !== want_word.sine) begin
                    $display("%0t: sine_value expected %h actual %h",
                             $time, want_word.sine, got_word.sine);
                    mismatch_count++;
                end
                if (got_word.sat !== want_word.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want_word.sat, got_word.sat);
                    mismatch_count++;
                end
                if (got_word.bad !== want_word.bad) begin
                    $display("%0t: bad_order expected %b actual %b",
                             $time, want_word.bad, got_word.bad);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with neither an accept nor a result ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d result words outstanding",
                         $time, sine_expect_q.size());
                $display("sine_taylor_series_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_angle         = '0;
        i_highest_power = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_angle_extremes();
        test_bad_orders();
        test_order_cap();
        test_low_orders();
        test_random_traffic(1000);
        test_back_to_back(300);

        idle_gap(1);
        while (sine_expect_q.size() != 0)
            @(posedge i_clk);
        // catch any stray strobe after the last expected word
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("sine_taylor_series_top regression: pass");
        else
            $display("sine_taylor_series_top regression: fail");
        $finish;
    end

endmodule
